// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");
`define LHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");
`else
`define LHC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/lhc_pkg.sv =====
// Shared constants and codes for the level and hue to RGB565 colour block.
package lhc_pkg;

    localparam int COLOR_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [2:0]           t_sector;
    typedef logic [COLOR_W-1:0]   t_color;

    localparam t_cfg_idx CFG_SATURATION  = 2'd0;
    localparam t_cfg_idx CFG_VALUE_FLOOR = 2'd1;
    localparam t_cfg_idx CFG_HUE_SPREAD  = 2'd2;

    localparam t_sector SECT_0 = 3'd0;
    localparam t_sector SECT_1 = 3'd1;
    localparam t_sector SECT_2 = 3'd2;
    localparam t_sector SECT_3 = 3'd3;
    localparam t_sector SECT_4 = 3'd4;
    localparam t_sector SECT_5 = 3'd5;

    localparam int SAT_RESET_PCT = 85;

    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;
    localparam logic [7:0] BYTE_MAX   = 8'hFF;

endpackage

// ===== design/lhc_in_if.sv =====
// Input request channel: display level and base hue.
interface lhc_in_if #(
    parameter int FRAC_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   level;
    logic [FRAC_BITS-1:0] hue;

    modport source (output valid, output level, output hue, input ready);
    modport sink   (input valid, input level, input hue, output ready);
endinterface

// ===== design/lhc_out_if.sv =====
// Output request channel: packed RGB565 colour.
interface lhc_out_if;
    logic                  valid;
    logic                  ready;
    lhc_pkg::t_color       color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

// ===== design/lhc_cfg_regs.sv =====
// Configuration registers with saturation of values above one.
module lhc_cfg_regs #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  lhc_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [FRAC_BITS:0]      i_cfg_data,
    output logic [FRAC_BITS:0]      o_sat,
    output logic [FRAC_BITS:0]      o_floor,
    output logic [FRAC_BITS:0]      o_spread
);

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] SAT_RST =
        (FRAC_BITS+1)'((ONE_L * lhc_pkg::SAT_RESET_PCT + 50) / 100);
    localparam logic [FRAC_BITS:0] QUARTER_RST = (FRAC_BITS+1)'(ONE_L / 4);

    logic [FRAC_BITS:0] r_sat;
    logic [FRAC_BITS:0] r_floor;
    logic [FRAC_BITS:0] r_spread;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= SAT_RST;
            r_floor  <= QUARTER_RST;
            r_spread <= QUARTER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lhc_pkg::CFG_SATURATION:  r_sat    <= i_cfg_data;
                lhc_pkg::CFG_VALUE_FLOOR: r_floor  <= i_cfg_data;
                lhc_pkg::CFG_HUE_SPREAD:  r_spread <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_sat    = (r_sat    > ONE) ? ONE : r_sat;
    assign o_floor  = (r_floor  > ONE) ? ONE : r_floor;
    assign o_spread = (r_spread > ONE) ? ONE : r_spread;

endmodule

// ===== design/level_hue_to_rgb565_color.sv =====
// Top level: level and hue to RGB565 colour, five-stage pipeline.
//
// Requests arrive on i_in (level and base hue, fixed point with FRAC_BITS
// fractional bits) and colours leave on o_out, both valid/ready channels.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; index 0
// is saturation, 1 the value floor and 2 the hue spread. Other indices are
// ignored. Registers should only be written while no request is in flight.
// Each request gives one colour. While the pipeline is not full and stalled,
// a new request can be accepted in every cycle: throughput is one per cycle.
// The depth is set by the chain of multipliers: hue and value, six-sector
// split, saturation products, value products, then byte scaling and packing.
// Every stage has its own valid bit and ready term, so a bubble anywhere is
// filled while the receiver stalls; when all five stages are full, i_in
// ready falls and nothing is lost or repeated. Synchronous reset empties the
// pipeline and loads the registers with 0.85, 0.25 and 0.25.
`include "assert_macros.svh"
module level_hue_to_rgb565_color #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  lhc_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [FRAC_BITS:0]      i_cfg_data,
    lhc_in_if.sink                  i_in,
    lhc_out_if.source               o_out
);

    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * F + 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [F:0] w_sat;
    logic [F:0] w_floor;
    logic [F:0] w_spread;
    logic [F:0] w_lev;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic [PW-1:0] r1_prod_hue;
    logic [PW-1:0] r1_prod_val;
    logic [F-1:0]  r1_hue;

    logic [F-1:0]  w2_h;
    logic [F:0]    w2_v;
    logic [F+2:0]  w2_h6;
    lhc_pkg::t_sector r2_sector;
    logic [F-1:0]  r2_f;
    logic [F:0]    r2_v;

    logic [PW-1:0] w3_prod_sf;
    logic [PW-1:0] w3_prod_s1f;
    logic [F-1:0]  r3_sf;
    logic [F:0]    r3_s1f;
    logic [F:0]    r3_v;
    lhc_pkg::t_sector r3_sector;

    logic [PW-1:0] w4_prod_p;
    logic [PW-1:0] w4_prod_q;
    logic [PW-1:0] w4_prod_t;
    logic [F:0]    r4_p;
    logic [F:0]    r4_q;
    logic [F:0]    r4_t;
    logic [F:0]    r4_v;
    lhc_pkg::t_sector r4_sector;

    logic [F:0]    w5_r;
    logic [F:0]    w5_g;
    logic [F:0]    w5_b;
    logic [7:0]    w5_rb;
    logic [7:0]    w5_gb;
    logic [7:0]    w5_bb;
    lhc_pkg::t_color r_color;

    function automatic logic [7:0] to_byte(input logic [F:0] x);
        logic [F+8:0] scaled;
        logic [8:0]   whole;
        scaled = {x, 8'b0} - {8'b0, x};
        whole  = scaled[F+8:F];
        to_byte = (whole > 9'({1'b0, lhc_pkg::BYTE_MAX})) ? lhc_pkg::BYTE_MAX : whole[7:0];
    endfunction

    lhc_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sat      (w_sat),
        .o_floor    (w_floor),
        .o_spread   (w_spread)
    );

    assign w_rdy5 = !r_v5 || o_out.ready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    assign w_lev = (i_in.level > ONE) ? ONE : i_in.level;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_prod_hue <= PW'(w_lev) * PW'(w_spread);
            r1_prod_val <= PW'(ONE - w_floor) * PW'(w_lev);
            r1_hue      <= i_in.hue;
        end
    end

    assign w2_h  = r1_hue + r1_prod_hue[2*F-1:F];
    assign w2_v  = w_floor + r1_prod_val[2*F:F];
    assign w2_h6 = {1'b0, w2_h, 2'b0} + {2'b0, w2_h, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_sector <= w2_h6[F+2:F];
            r2_f      <= w2_h6[F-1:0];
            r2_v      <= w2_v;
        end
    end

    assign w3_prod_sf  = PW'(w_sat) * PW'(r2_f);
    assign w3_prod_s1f = PW'(w_sat) * PW'(ONE - {1'b0, r2_f});

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_sf     <= w3_prod_sf[2*F-1:F];
            r3_s1f    <= w3_prod_s1f[2*F:F];
            r3_v      <= r2_v;
            r3_sector <= r2_sector;
        end
    end

    assign w4_prod_p = PW'(r3_v) * PW'(ONE - w_sat);
    assign w4_prod_q = PW'(r3_v) * PW'(ONE - {1'b0, r3_sf});
    assign w4_prod_t = PW'(r3_v) * PW'(ONE - r3_s1f);

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_p      <= w4_prod_p[2*F:F];
            r4_q      <= w4_prod_q[2*F:F];
            r4_t      <= w4_prod_t[2*F:F];
            r4_v      <= r3_v;
            r4_sector <= r3_sector;
        end
    end

    always_comb begin
        case (r4_sector)
            lhc_pkg::SECT_0: begin
                w5_r = r4_v; w5_g = r4_t; w5_b = r4_p;
            end
            lhc_pkg::SECT_1: begin
                w5_r = r4_q; w5_g = r4_v; w5_b = r4_p;
            end
            lhc_pkg::SECT_2: begin
                w5_r = r4_p; w5_g = r4_v; w5_b = r4_t;
            end
            lhc_pkg::SECT_3: begin
                w5_r = r4_p; w5_g = r4_q; w5_b = r4_v;
            end
            lhc_pkg::SECT_4: begin
                w5_r = r4_t; w5_g = r4_p; w5_b = r4_v;
            end
            default: begin
                w5_r = r4_v; w5_g = r4_p; w5_b = r4_q;
            end
        endcase
    end

    assign w5_rb = to_byte(w5_r) & lhc_pkg::RED_MASK;
    assign w5_gb = to_byte(w5_g) & lhc_pkg::GREEN_MASK;
    assign w5_bb = to_byte(w5_b);

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_color <= {w5_rb[7:3], w5_gb[7:2], w5_bb[7:3]};
        end
    end

    assign o_out.valid = r_v5;
    assign o_out.color = r_color;

    `LHC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_v1)
    `LHC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, r_v5 && !o_out.ready, r_v5 && $stable(r_color))
    `LHC_ASSERT_NEXT(a_mid_holds, i_clk, i_rst_n, r_v3 && !w_rdy3, r_v3 && $stable(r3_v))
    `LHC_ASSERT_NOW(a_sector_range, i_clk, i_rst_n, r_v2, r2_sector <= lhc_pkg::SECT_5)

endmodule
